### src/dsc_pkg.sv
`timescale 1ns / 1ps
// Package for the divisor sum number classifier.
// Holds class codes, result field widths and controller/datapath link types.
package dsc_pkg;

	localparam int CLASS_W     = 2;
	localparam int SUM_W       = 19;
	localparam int OUT_TDATA_W = ((CLASS_W + SUM_W + 7) / 8) * 8;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	typedef enum logic [CLASS_W-1:0] {
		CLASS_PERFECT   = 2'd0,
		CLASS_DEFICIENT = 2'd1,
		CLASS_ABUNDANT  = 2'd2,
		CLASS_INVALID   = 2'd3
	} class_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_step;
		logic accum;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic cand_done;
		logic last_step;
		logic rem_zero;
	} status_t;

endpackage

### src/dsc_datapath.sv
`timescale 1ns / 1ps
// Datapath of the divisor sum number classifier: candidate counter, serial
// restoring remainder unit, divisor accumulator and result register. Uses dsc_pkg.
module dsc_datapath #(
	parameter int NUM_WIDTH = 16
) (
	input  logic                                clk,
	input  logic [NUM_WIDTH-1:0]                number,
	input  dsc_pkg::cmd_t                       cmd,
	output dsc_pkg::status_t                    status,
	output logic [dsc_pkg::CLASS_W-1:0]         number_class,
	output logic [dsc_pkg::SUM_W-1:0]           divisor_sum
);

	localparam int ACC_W = NUM_WIDTH + 3;
	localparam int CMP_W = (ACC_W > dsc_pkg::SUM_W) ? ACC_W : dsc_pkg::SUM_W;
	localparam int CNT_W = $clog2(NUM_WIDTH);

	logic [NUM_WIDTH-1:0] n_q;
	logic [NUM_WIDTH-1:0] half_q;
	logic [NUM_WIDTH-1:0] cand_q;
	logic [NUM_WIDTH-1:0] rem_q;
	logic [NUM_WIDTH-1:0] shift_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [ACC_W-1:0]     acc_q;
	logic [dsc_pkg::CLASS_W-1:0] class_q;
	logic [dsc_pkg::SUM_W-1:0]   sum_q;

	logic [NUM_WIDTH:0]   trial;
	logic                 fits;
	logic [CMP_W-1:0]     acc_ext;
	logic [CMP_W-1:0]     n_ext;
	logic                 sat;
	dsc_pkg::class_t      class_d;

	assign trial = {rem_q, shift_q[NUM_WIDTH-1]};
	assign fits  = trial >= {1'b0, cand_q};

	assign acc_ext = CMP_W'(acc_q);
	assign n_ext   = CMP_W'(n_q);
	assign sat     = acc_ext > CMP_W'(dsc_pkg::SUM_MAX);

	always_comb begin
		if (n_q == '0) begin
			class_d = dsc_pkg::CLASS_INVALID;
		end else if (acc_ext == n_ext) begin
			class_d = dsc_pkg::CLASS_PERFECT;
		end else if (acc_ext < n_ext) begin
			class_d = dsc_pkg::CLASS_DEFICIENT;
		end else begin
			class_d = dsc_pkg::CLASS_ABUNDANT;
		end
	end

	assign status.cand_done = cand_q > half_q;
	assign status.last_step = cnt_q == CNT_W'(NUM_WIDTH - 1);
	assign status.rem_zero  = rem_q == '0;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= number;
			half_q <= number >> 1;
			cand_q <= NUM_WIDTH'(1);
			acc_q  <= '0;
		end
		if (cmd.div_start) begin
			rem_q   <= '0;
			shift_q <= n_q;
			cnt_q   <= '0;
		end
		if (cmd.div_step) begin
			rem_q   <= fits ? NUM_WIDTH'(trial - {1'b0, cand_q}) : trial[NUM_WIDTH-1:0];
			shift_q <= shift_q << 1;
			cnt_q   <= cnt_q + CNT_W'(1);
		end
		if (cmd.accum) begin
			if (status.rem_zero) begin
				acc_q <= acc_q + ACC_W'(cand_q);
			end
			cand_q <= cand_q + NUM_WIDTH'(1);
		end
		if (cmd.emit) begin
			class_q <= class_d;
			sum_q   <= sat ? dsc_pkg::SUM_MAX : acc_ext[dsc_pkg::SUM_W-1:0];
		end
	end

	assign number_class = class_q;
	assign divisor_sum  = sum_q;

endmodule

### src/dsc_ctrl.sv
`timescale 1ns / 1ps
// Controller of the divisor sum number classifier: sequences candidates and
// remainder steps, owns both handshakes. Uses dsc_pkg.
module dsc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  dsc_pkg::status_t  status,
	output dsc_pkg::cmd_t     cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CHECK  = 5'b00010,
		ST_DIVIDE = 5'b00100,
		ST_ACCUM  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.cand_done) begin
					state_d = ST_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (status.last_step) begin
					state_d = ST_ACCUM;
				end
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### src/divisor_sum_number_classifier.sv
`timescale 1ns / 1ps
// Divisor sum number classifier, top level: controller plus datapath.
// Depends on dsc_pkg, dsc_ctrl and dsc_datapath.
//
// Each input number n is classified by summing all its divisors d from 1 up
// to floor(n/2); every candidate is tested with a bit-serial restoring
// remainder over every bit of n, between a check and an accumulate step.
// The serial remainder loop dominates the processing time. Items are handled
// one at a time. The result register lets the next number be accepted while
// the previous result waits on m_tready. Zero is reported as invalid with
// sum 0; a sum above 524287 saturates while the class is still decided from
// the full sum.
module divisor_sum_number_classifier #(
	parameter int NUM_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((NUM_WIDTH+7)/8)*8-1:0]       s_tdata,   // number
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [dsc_pkg::OUT_TDATA_W-1:0]      m_tdata    // number_class, divisor_sum
);

	dsc_pkg::cmd_t    cmd;
	dsc_pkg::status_t status;
	logic [dsc_pkg::CLASS_W-1:0] number_class;
	logic [dsc_pkg::SUM_W-1:0]   divisor_sum;

	dsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	dsc_datapath #(
		.NUM_WIDTH (NUM_WIDTH)
	) u_datapath (
		.clk          (clk),
		.number       (s_tdata[NUM_WIDTH-1:0]),
		.cmd          (cmd),
		.status       (status),
		.number_class (number_class),
		.divisor_sum  (divisor_sum)
	);

	assign m_tdata = dsc_pkg::OUT_TDATA_W'({divisor_sum, number_class});

endmodule

### src/dsc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the divisor sum number classifier, bound to the top.
// Depends on dsc_pkg.
module dsc_checker #(
	parameter int NUM_WIDTH = 16
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [((NUM_WIDTH+7)/8)*8-1:0]    s_tdata,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [dsc_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	logic [dsc_pkg::CLASS_W-1:0] out_class;
	logic [dsc_pkg::SUM_W-1:0]   out_sum;

	assign out_class = m_tdata[dsc_pkg::CLASS_W-1:0];
	assign out_sum   = m_tdata[dsc_pkg::CLASS_W+dsc_pkg::SUM_W-1:dsc_pkg::CLASS_W];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a number is in work");

	a_invalid_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_class == dsc_pkg::CLASS_INVALID |-> out_sum == '0)
		else $error("invalid class with nonzero sum");

	a_perfect_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_class == dsc_pkg::CLASS_PERFECT |-> out_sum != '0)
		else $error("perfect class with zero sum");

	a_abundant_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_class == dsc_pkg::CLASS_ABUNDANT |-> out_sum != '0)
		else $error("abundant class with zero sum");

endmodule

bind divisor_sum_number_classifier dsc_checker #(.NUM_WIDTH(NUM_WIDTH)) u_checker (.*);
